/* hdl/tes_pkg.sv */
// ----------------------------------------------------------------------------
// tes_pkg
// types, codes and controller interface of the timeline sequencer
// ----------------------------------------------------------------------------
package tes_pkg;

	localparam int unsigned SCAN_W = 6;
	localparam int unsigned DIV_STEPS = 16;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	localparam logic [2:0] OP_ADD_EVENT = 3'd0;
	localparam logic [2:0] OP_ADD_TWEEN = 3'd1;
	localparam logic [2:0] OP_ADD_WINDOW = 3'd2;
	localparam logic [2:0] OP_PLAY = 3'd3;
	localparam logic [2:0] OP_STOP = 3'd4;
	localparam logic [2:0] OP_TICK = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_EVENT = 2'd1;
	localparam logic [1:0] KIND_TWEEN = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_SMOOTH = 2'd1;
	localparam logic [1:0] EASE_IN = 2'd2;
	localparam logic [1:0] EASE_OUT = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] time_a;
		logic [31:0] time_b;
		logic [1:0]  ease;
		logic [31:0] delta;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  index;
		logic [16:0] value;
		logic [1:0]  status;
		logic        playing;
		logic        input_blocked;
		logic        last;
	} rsp_t;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_WIN    = 10'b0000000010,
		S_EVSCAN = 10'b0000000100,
		S_EVEMIT = 10'b0000001000,
		S_TWCHK  = 10'b0000010000,
		S_TWDIV  = 10'b0000100000,
		S_TWMUL1 = 10'b0001000000,
		S_TWMUL2 = 10'b0010000000,
		S_TWEMIT = 10'b0100000000,
		S_STEMIT = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_clr;
		logic win_step;
		logic ev_step;
		logic ev_fire;
		logic tw_skip;
		logic tw_load;
		logic div_step;
		logic mul1;
		logic mul2;
		logic tw_push;
		logic st_push;
	} cmd_t;

	typedef struct packed {
		logic win_end;
		logic ev_end;
		logic ev_found;
		logic tw_end;
		logic tw_skip;
		logic tw_full;
		logic tick_act;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* hdl/tes_ctrl.sv */
// ----------------------------------------------------------------------------
// tes_ctrl
// sequencing state machine: window scan, event passes, tween updates, status
// ----------------------------------------------------------------------------
module tes_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tes_pkg::sts_t sts,
	output tes_pkg::cmd_t cmd
);
	import tes_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_WIN;
				end
			end
			S_WIN: begin
				if (sts.win_end) begin
					cmd.scan_clr = 1'b1;
					state_d = sts.tick_act ? S_EVSCAN : S_STEMIT;
				end else begin
					cmd.win_step = 1'b1;
				end
			end
			S_EVSCAN: begin
				if (sts.ev_end) begin
					cmd.scan_clr = 1'b1;
					state_d = sts.ev_found ? S_EVEMIT : S_TWCHK;
				end else begin
					cmd.ev_step = 1'b1;
				end
			end
			S_EVEMIT: begin
				if (sts.out_free) begin
					cmd.ev_fire = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_EVSCAN;
				end
			end
			S_TWCHK: begin
				priority if (sts.tw_end) begin
					state_d = S_STEMIT;
				end else if (sts.tw_skip) begin
					cmd.tw_skip = 1'b1;
				end else begin
					cmd.tw_load = 1'b1;
					state_d = sts.tw_full ? S_TWEMIT : S_TWDIV;
				end
			end
			S_TWDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_TWMUL1;
				end
			end
			S_TWMUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_TWMUL2;
			end
			S_TWMUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_TWEMIT;
			end
			S_TWEMIT: begin
				if (sts.out_free) begin
					cmd.tw_push = 1'b1;
					state_d = S_TWCHK;
				end
			end
			S_STEMIT: begin
				if (sts.out_free) begin
					cmd.st_push = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/tes_dp.sv */
// ----------------------------------------------------------------------------
// tes_dp
// tables, elapsed time, serial scans, radix-2 divider, multiplier, item out
// ----------------------------------------------------------------------------
module tes_dp #(
	parameter int unsigned MAX_EVENTS  = 16,
	parameter int unsigned MAX_TWEENS  = 16,
	parameter int unsigned MAX_WINDOWS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tes_pkg::req_t req,
	input  tes_pkg::cmd_t cmd,
	output tes_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tes_pkg::rsp_t rsp
);
	import tes_pkg::*;

	localparam int unsigned ECW = $clog2(MAX_EVENTS + 1);
	localparam int unsigned TCW = $clog2(MAX_TWEENS + 1);
	localparam int unsigned WCW = $clog2(MAX_WINDOWS + 1);
	localparam int unsigned EIW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int unsigned TIW = (MAX_TWEENS > 1) ? $clog2(MAX_TWEENS) : 1;
	localparam int unsigned WIW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int unsigned DCW = $clog2(DIV_STEPS);

	logic [31:0] ev_time_q [MAX_EVENTS];
	logic [31:0] tw_start_q [MAX_TWEENS];
	logic [31:0] tw_end_q [MAX_TWEENS];
	logic [1:0]  tw_ease_q [MAX_TWEENS];
	logic [31:0] win_start_q [MAX_WINDOWS];
	logic [31:0] win_end_q [MAX_WINDOWS];

	logic [MAX_EVENTS-1:0] fired_q;
	logic [MAX_TWEENS-1:0] done_q;
	logic [ECW-1:0] ev_cnt_q;
	logic [TCW-1:0] tw_cnt_q;
	logic [WCW-1:0] win_cnt_q;
	logic [31:0] elapsed_q, total_q;
	logic run_q, blk_q, tick_q;
	logic [1:0] st_q;
	logic [4:0] idx_q;

	logic [SCAN_W-1:0] scan_q;
	logic found_q;
	logic [EIW-1:0] best_q;
	logic [31:0] best_time_q;

	logic [31:0] rem_q, span_q;
	logic [15:0] quo_q;
	logic [DCW-1:0] div_cnt_q;
	logic [1:0] ease_q;
	logic full_q;
	logic [32:0] prod1_q;
	logic [49:0] prod2_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [EIW-1:0] ei;
	logic [TIW-1:0] ti;
	logic [WIW-1:0] wi;
	logic [32:0] sum;
	logic [31:0] el_next;
	logic [32:0] shifted;
	logic [16:0] ux;
	logic [32:0] ma;
	logic [17:0] mb;
	logic [50:0] mprod;
	logic [16:0] tw_val;
	logic out_free;
	logic [31:0] cur_s, cur_e;
	logic [1:0] acc_st;
	logic [4:0] acc_idx;

	assign ei = scan_q[EIW-1:0];
	assign ti = scan_q[TIW-1:0];
	assign wi = scan_q[WIW-1:0];
	assign cur_s = tw_start_q[ti];
	assign cur_e = tw_end_q[ti];
	assign sum = {1'b0, elapsed_q} + {1'b0, req.delta};
	assign el_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	assign shifted = {rem_q, 1'b0};
	assign ux = (ease_q == EASE_OUT) ? (ONE_Q16 - {1'b0, quo_q}) : {1'b0, quo_q};
	assign ma = cmd.mul2 ? prod1_q : {16'd0, ux};
	assign mb = cmd.mul2 ? (THREE_Q16 - {1'b0, quo_q, 1'b0}) : {1'b0, ux};
	assign mprod = ma * mb;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (full_q) begin
			tw_val = ONE_Q16;
		end else begin
			unique case (ease_q)
				EASE_LINEAR: tw_val = {1'b0, quo_q};
				EASE_SMOOTH: tw_val = {1'b0, prod2_q[47:32]};
				EASE_IN:     tw_val = {1'b0, prod1_q[31:16]};
				EASE_OUT:    tw_val = ONE_Q16 - prod1_q[32:16];
				default:     tw_val = {1'b0, quo_q};
			endcase
		end
	end

	// status and index of an authoring item
	always_comb begin
		acc_st = ST_OK;
		acc_idx = '0;
		unique case (req.operation)
			OP_ADD_EVENT: begin
				priority if (run_q) begin
					acc_st = ST_BUSY;
				end else if (ev_cnt_q >= ECW'(MAX_EVENTS)) begin
					acc_st = ST_FULL;
				end else begin
					acc_idx = 5'(ev_cnt_q);
				end
			end
			OP_ADD_TWEEN: begin
				priority if (run_q) begin
					acc_st = ST_BUSY;
				end else if (req.time_b < req.time_a) begin
					acc_st = ST_ORDER;
				end else if (tw_cnt_q >= TCW'(MAX_TWEENS)) begin
					acc_st = ST_FULL;
				end else begin
					acc_idx = 5'(tw_cnt_q);
				end
			end
			OP_ADD_WINDOW: begin
				priority if (run_q) begin
					acc_st = ST_BUSY;
				end else if (req.time_b < req.time_a) begin
					acc_st = ST_ORDER;
				end else if (win_cnt_q >= WCW'(MAX_WINDOWS)) begin
					acc_st = ST_FULL;
				end else begin
					acc_idx = 5'(win_cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.win_end = (scan_q == SCAN_W'(win_cnt_q));
	assign sts.ev_end = (scan_q == SCAN_W'(ev_cnt_q));
	assign sts.tw_end = (scan_q == SCAN_W'(tw_cnt_q));
	assign sts.ev_found = found_q;
	assign sts.tw_skip = done_q[ti] || (elapsed_q < cur_s);
	assign sts.tw_full = (elapsed_q >= cur_e);
	assign sts.tick_act = tick_q;
	assign sts.div_last = (div_cnt_q == DCW'(DIV_STEPS - 1));
	assign sts.out_free = out_free;

	// tables, written only by authoring
	always_ff @(posedge clk) begin
		if (cmd.accept && !run_q) begin
			unique case (req.operation)
				OP_ADD_EVENT: begin
					if (ev_cnt_q < ECW'(MAX_EVENTS)) begin
						ev_time_q[ev_cnt_q[EIW-1:0]] <= req.time_a;
					end
				end
				OP_ADD_TWEEN: begin
					if (req.time_b >= req.time_a && tw_cnt_q < TCW'(MAX_TWEENS)) begin
						tw_start_q[tw_cnt_q[TIW-1:0]] <= req.time_a;
						tw_end_q[tw_cnt_q[TIW-1:0]] <= req.time_b;
						tw_ease_q[tw_cnt_q[TIW-1:0]] <= req.ease;
					end
				end
				OP_ADD_WINDOW: begin
					if (req.time_b >= req.time_a && win_cnt_q < WCW'(MAX_WINDOWS)) begin
						win_start_q[win_cnt_q[WIW-1:0]] <= req.time_a;
						win_end_q[win_cnt_q[WIW-1:0]] <= req.time_b;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// control state of the timeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= '0;
			done_q <= '0;
			ev_cnt_q <= '0;
			tw_cnt_q <= '0;
			win_cnt_q <= '0;
			elapsed_q <= '0;
			total_q <= '0;
			run_q <= 1'b0;
			blk_q <= 1'b0;
			tick_q <= 1'b0;
			st_q <= ST_OK;
			idx_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			div_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ev_fire || cmd.tw_push || cmd.st_push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.accept) begin
				st_q <= acc_st;
				idx_q <= acc_idx;
				blk_q <= 1'b0;
				tick_q <= (req.operation == OP_TICK) && run_q;
				unique case (req.operation)
					OP_ADD_EVENT: begin
						if (acc_st == ST_OK) begin
							fired_q[ev_cnt_q[EIW-1:0]] <= 1'b0;
							ev_cnt_q <= ev_cnt_q + 1'b1;
							if (req.time_a > total_q) total_q <= req.time_a;
						end
					end
					OP_ADD_TWEEN: begin
						if (acc_st == ST_OK) begin
							done_q[tw_cnt_q[TIW-1:0]] <= 1'b0;
							tw_cnt_q <= tw_cnt_q + 1'b1;
							if (req.time_b > total_q) total_q <= req.time_b;
						end
					end
					OP_ADD_WINDOW: begin
						if (acc_st == ST_OK) begin
							win_cnt_q <= win_cnt_q + 1'b1;
							if (req.time_b > total_q) total_q <= req.time_b;
						end
					end
					OP_PLAY: begin
						elapsed_q <= '0;
						fired_q <= '0;
						done_q <= '0;
						run_q <= 1'b1;
					end
					OP_STOP: begin
						run_q <= 1'b0;
					end
					OP_TICK: begin
						if (run_q) begin
							elapsed_q <= el_next;
							if (el_next >= total_q) run_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.win_step) begin
				scan_q <= scan_q + 1'b1;
				if (run_q && elapsed_q >= win_start_q[wi] && elapsed_q <= win_end_q[wi]) begin
					blk_q <= 1'b1;
				end
			end
			if (cmd.ev_step) begin
				scan_q <= scan_q + 1'b1;
				if (!fired_q[ei] && ev_time_q[ei] <= elapsed_q
						&& (!found_q || ev_time_q[ei] < best_time_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.ev_fire) begin
				fired_q[best_q] <= 1'b1;
			end
			if (cmd.tw_skip) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.tw_load) begin
				div_cnt_q <= '0;
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.tw_push) begin
				scan_q <= scan_q + 1'b1;
				if (full_q) done_q[ti] <= 1'b1;
			end
		end
	end

	// scan, divider and multiplier payload
	always_ff @(posedge clk) begin
		if (cmd.ev_step && !fired_q[ei] && ev_time_q[ei] <= elapsed_q
				&& (!found_q || ev_time_q[ei] < best_time_q)) begin
			best_q <= ei;
			best_time_q <= ev_time_q[ei];
		end
		if (cmd.tw_load) begin
			full_q <= (elapsed_q >= cur_e);
			ease_q <= tw_ease_q[ti];
			rem_q <= elapsed_q - cur_s;
			span_q <= cur_e - cur_s;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (shifted >= {1'b0, span_q}) begin
				rem_q <= 32'(shifted - {1'b0, span_q});
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.mul1) begin
			prod1_q <= mprod[32:0];
		end
		if (cmd.mul2) begin
			prod2_q <= mprod[49:0];
		end
		if (cmd.ev_fire) begin
			rsp_q <= '{kind: KIND_EVENT, index: 5'(best_q), value: '0, status: ST_OK,
				playing: run_q, input_blocked: blk_q, last: 1'b0};
		end
		if (cmd.tw_push) begin
			rsp_q <= '{kind: KIND_TWEEN, index: 5'(ti), value: tw_val, status: ST_OK,
				playing: run_q, input_blocked: blk_q, last: 1'b0};
		end
		if (cmd.st_push) begin
			rsp_q <= '{kind: KIND_STATUS, index: idx_q, value: '0, status: st_q,
				playing: run_q, input_blocked: blk_q, last: 1'b1};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* hdl/timed_event_tween_sequencer_top.sv */
// ----------------------------------------------------------------------------
// timed_event_tween_sequencer_top
// timeline sequencer with one-shot events, eased tweens and block windows
// ----------------------------------------------------------------------------
// One item is taken at a time. Every item is accepted, scans the window table
// and ends with its status item. A tick that runs also makes one pass over the
// event table per fired event plus a final pass, with one output per fired
// event, then checks each tween; a tween in progress goes through the divider
// and the multiplier steps before its output, and a tween that reaches its end
// has only the output. Output stalls add to this. Results leave through a
// one-entry output register, so the last item of a step may still wait there
// while the next item is taken.
module timed_event_tween_sequencer_top #(
	parameter int unsigned MAX_EVENTS  = 16,
	parameter int unsigned MAX_TWEENS  = 16,
	parameter int unsigned MAX_WINDOWS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tes_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tes_pkg::rsp_t rsp
);
	import tes_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tes_dp #(
		.MAX_EVENTS  (MAX_EVENTS),
		.MAX_TWEENS  (MAX_TWEENS),
		.MAX_WINDOWS (MAX_WINDOWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.kind == KIND_STATUS) == rsp.last))
		else $error("status item and last flag disagree");

	a_blocked_playing: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.input_blocked |-> rsp.playing)
		else $error("input blocked while stopped");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.value <= ONE_Q16))
		else $error("tween value above one");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tw_push || cmd.ev_fire || cmd.st_push) |-> (!rsp_valid || !rsp_stall))
		else $error("item pushed over a held item");

endmodule
